// ----- hw/rtl/bhpq_pkg.sv -----
// shared types, constants and helpers of the binary heap priority queue
`timescale 1ns / 1ps

package bhpq_pkg;

    localparam int CAPACITY     = 64;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 16;
    localparam int IDX_BITS     = $clog2(CAPACITY);
    localparam int CNT_BITS     = $clog2(CAPACITY + 1);
    localparam int CMP_BITS     = IDX_BITS + 2;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // datapath operation codes
    typedef logic [2:0] dp_op_t;
    localparam dp_op_t OP_NONE    = 3'd0;
    localparam dp_op_t OP_ACCEPT  = 3'd1;
    localparam dp_op_t OP_UP      = 3'd2;
    localparam dp_op_t OP_RM_LOAD = 3'd3;
    localparam dp_op_t OP_DN      = 3'd4;
    localparam dp_op_t OP_FIN     = 3'd5;
    localparam dp_op_t OP_RESP    = 3'd6;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] data;
    } entry_t;

    // datapath flags seen by the controller
    typedef struct packed {
        logic is_insert;
        logic is_remove;
        logic full;
        logic empty;
        logic up_move;
        logic up_next_root;
        logic root_has_child;
        logic dn_move;
        logic dn_next_has_child;
        logic out_free;
    } dp_stat_t;

    // true when key a ranks strictly below key b
    function automatic logic ranks_below(
        input logic [KEY_BITS-1:0] a,
        input logic [KEY_BITS-1:0] b,
        input logic                min_order
    );
        ranks_below = min_order ? (a > b) : (a < b);
    endfunction

endpackage

// ----- hw/rtl/binary_heap_priority_queue.sv -----
// top level of the binary heap priority queue
`timescale 1ns / 1ps

// Binary heap priority queue of up to 64 key/payload entries held in one
// array with two registered read ports and one write port. Each transaction
// on the input carries a command: insert sifts the new entry up from the next
// free slot, remove returns the root and sifts the last entry down from the
// root, clear empties the heap. Every transaction gives exactly one result
// transaction carrying the removed root (zero unless a remove succeeded), a
// status (done, refused full, refused empty) and the entry count afterwards.
// cfg_write_data written with cfg_write_en picks the ordering: 0 keeps the
// largest key at the root, 1 the smallest; change it only while idle, the
// held entries are not reordered. One command is worked on at a time; the
// heap walk takes one step per level, since each level needs the registered
// read of the parent or of both children before the compare and write. An
// insert sifts up one step per level moved, then writes the entry; a remove
// first loads the root and the last entry, then sifts down. An entry moves
// at most 6 levels on an insert, 5 on a remove; clear, refused and unused
// commands go straight to the result hand-off. The result sits in an output
// register, so the next command is taken while the previous result waits.

module binary_heap_priority_queue
    import bhpq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // command channel
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              command,
    input  logic [KEY_BITS-1:0]     priority_key,
    input  logic [PAYLOAD_BITS-1:0] payload,
    // result channel
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [KEY_BITS-1:0]     top_key,
    output logic [PAYLOAD_BITS-1:0] top_payload,
    output logic [1:0]              status,
    output logic [CNT_BITS-1:0]     fill_count,
    // ordering register
    input  logic                    cfg_write_en,
    input  logic                    cfg_write_data
);

    dp_stat_t stat;
    dp_op_t   op;

    // sequencer: accept, sift steps, final write, result hand-off
    bhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .op       (op)
    );

    // storage, compares and result register
    bhpq_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .stat           (stat),
        .command        (command),
        .priority_key   (priority_key),
        .payload        (payload),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .top_key        (top_key),
        .top_payload    (top_payload),
        .status         (status),
        .fill_count     (fill_count)
    );

`ifndef SYNTHESIS
    // count never passes the capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fill_count <= CNT_BITS'(CAPACITY))
        else $error("fill count above capacity");

    // a refused command returns no entry
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DONE) |-> (top_key == '0 && top_payload == '0))
        else $error("refused command returned an entry");

    // one command at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second command taken while busy");

    // a refused insert leaves a full heap
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> fill_count == CNT_BITS'(CAPACITY))
        else $error("full status with room left");
`endif

endmodule

// ----- hw/rtl/bhpq_ctrl.sv -----
// controller state machine of the binary heap priority queue
`timescale 1ns / 1ps

module bhpq_ctrl
    import bhpq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_op_t   op
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1;
    localparam logic [2:0] S_RM   = 3'd2;
    localparam logic [2:0] S_DN   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op = OP_ACCEPT;
                    priority if (stat.is_insert && !stat.full)
                        state_next = stat.empty ? S_FIN : S_UP;
                    else if (stat.is_remove && !stat.empty)
                        state_next = S_RM;
                    else
                        state_next = S_RESP;
                end
            end
            S_UP:
            begin
                op = OP_UP;
                if (stat.up_move)
                    state_next = stat.up_next_root ? S_FIN : S_UP;
                else
                    state_next = S_RESP;
            end
            S_RM:
            begin
                op         = OP_RM_LOAD;
                state_next = stat.root_has_child ? S_DN : S_FIN;
            end
            S_DN:
            begin
                op = OP_DN;
                if (stat.dn_move)
                    state_next = stat.dn_next_has_child ? S_DN : S_FIN;
                else
                    state_next = S_RESP;
            end
            S_FIN:
            begin
                op         = OP_FIN;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    op         = OP_RESP;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- hw/rtl/bhpq_datapath.sv -----
// heap storage, index registers, comparators and result register
`timescale 1ns / 1ps

module bhpq_datapath
    import bhpq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_op_t                  op,
    output dp_stat_t                stat,
    input  logic [1:0]              command,
    input  logic [KEY_BITS-1:0]     priority_key,
    input  logic [PAYLOAD_BITS-1:0] payload,
    input  logic                    cfg_write_en,
    input  logic                    cfg_write_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [KEY_BITS-1:0]     top_key,
    output logic [PAYLOAD_BITS-1:0] top_payload,
    output logic [1:0]              status,
    output logic [CNT_BITS-1:0]     fill_count
);

    function automatic logic [IDX_BITS-1:0] parent_of(input logic [IDX_BITS-1:0] idx);
        logic [IDX_BITS-1:0] dec;
        dec       = idx - IDX_BITS'(1);
        parent_of = dec >> 1;
    endfunction

    entry_t mem [CAPACITY];
    entry_t rd_a_reg, rd_b_reg;

    logic                order_reg;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [IDX_BITS-1:0] hole_reg, hole_next;
    entry_t              mv_reg, mv_next;
    entry_t              top_reg, top_next;
    logic [1:0]          st_reg, st_next;

    logic                out_valid_reg;
    entry_t              out_top_reg;
    logic [1:0]          out_st_reg;
    logic [CNT_BITS-1:0] out_fill_reg;

    logic                we;
    logic [IDX_BITS-1:0] wa, ra, rb;
    entry_t              wd;

    logic [CMP_BITS-1:0] count_x, left_x, right_x, next_left_x;
    logic                right_ok, pick_right;
    entry_t              chosen;
    logic [IDX_BITS-1:0] chosen_idx, up_idx, acc_hole;
    logic [CNT_BITS-1:0] count_dec;

    // child selection for the sift-down step
    assign count_x     = CMP_BITS'(count_reg);
    assign left_x      = {1'b0, hole_reg, 1'b1};
    assign right_x     = left_x + CMP_BITS'(1);
    assign right_ok    = right_x < count_x;
    assign pick_right  = right_ok && ranks_below(rd_a_reg.key, rd_b_reg.key, order_reg);
    assign chosen      = pick_right ? rd_b_reg : rd_a_reg;
    assign chosen_idx  = pick_right ? right_x[IDX_BITS-1:0] : left_x[IDX_BITS-1:0];
    assign next_left_x = {1'b0, chosen_idx, 1'b1};

    assign up_idx    = parent_of(hole_reg);
    assign acc_hole  = count_reg[IDX_BITS-1:0];
    assign count_dec = count_reg - CNT_BITS'(1);

    assign stat.is_insert         = (command == CMD_INSERT);
    assign stat.is_remove         = (command == CMD_REMOVE);
    assign stat.full              = (count_reg == CNT_BITS'(CAPACITY));
    assign stat.empty             = (count_reg == '0);
    assign stat.up_move           = ranks_below(rd_a_reg.key, mv_reg.key, order_reg);
    assign stat.up_next_root      = (up_idx == '0);
    assign stat.root_has_child    = CMP_BITS'(1) < count_x;
    assign stat.dn_move           = ranks_below(mv_reg.key, chosen.key, order_reg);
    assign stat.dn_next_has_child = next_left_x < count_x;
    assign stat.out_free          = !out_valid_reg || out_ready;

    always_comb
    begin
        count_next = count_reg;
        hole_next  = hole_reg;
        mv_next    = mv_reg;
        top_next   = top_reg;
        st_next    = st_reg;
        we         = 1'b0;
        wa         = hole_reg;
        wd         = mv_reg;
        ra         = '0;
        rb         = '0;
        unique case (op)
            OP_ACCEPT:
            begin
                mv_next  = '{key: priority_key, data: payload};
                top_next = '0;
                st_next  = ST_DONE;
                if (stat.is_insert)
                begin
                    if (stat.full)
                        st_next = ST_FULL;
                    else
                    begin
                        hole_next  = acc_hole;
                        count_next = count_reg + CNT_BITS'(1);
                        ra         = parent_of(acc_hole);
                    end
                end
                else if (stat.is_remove)
                begin
                    if (stat.empty)
                        st_next = ST_EMPTY;
                    else
                    begin
                        hole_next  = '0;
                        count_next = count_dec;
                        rb         = count_dec[IDX_BITS-1:0];
                    end
                end
                else if (command == CMD_CLEAR)
                    count_next = '0;
            end
            OP_UP:
            begin
                we = 1'b1;
                if (stat.up_move)
                begin
                    wd        = rd_a_reg;
                    hole_next = up_idx;
                    ra        = parent_of(up_idx);
                end
            end
            OP_RM_LOAD:
            begin
                top_next = rd_a_reg;
                mv_next  = rd_b_reg;
                ra       = IDX_BITS'(1);
                rb       = IDX_BITS'(2);
            end
            OP_DN:
            begin
                we = 1'b1;
                if (stat.dn_move)
                begin
                    wd        = chosen;
                    hole_next = chosen_idx;
                    ra        = next_left_x[IDX_BITS-1:0];
                    rb        = next_left_x[IDX_BITS-1:0] + IDX_BITS'(1);
                end
            end
            OP_FIN:
            begin
                we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // heap storage, two registered read ports and one write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_a_reg <= mem[ra];
        rd_b_reg <= mem[rb];
    end

    always_ff @(posedge clk)
    begin
        hole_reg <= hole_next;
        mv_reg   <= mv_next;
        top_reg  <= top_next;
        st_reg   <= st_next;
        if (op == OP_RESP)
        begin
            out_top_reg  <= top_reg;
            out_st_reg   <= st_reg;
            out_fill_reg <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            order_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_write_en)
                order_reg <= cfg_write_data;
            if (op == OP_RESP)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign top_key     = out_top_reg.key;
    assign top_payload = out_top_reg.data;
    assign status      = out_st_reg;
    assign fill_count  = out_fill_reg;

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench of the binary heap priority queue
`timescale 1ns / 1ps

module tb_top;
    import bhpq_pkg::*;

    // the block takes command code 3 and ignores it
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned ITEM_TARGET = 1750;
    // no idling once this many commands have gone in
    localparam int unsigned CALM_FROM = 1500;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned LONG_HOLD = 300;

    // holds the software heap and the results it predicts, checks what comes out
    class heap_scoreboard;
        typedef struct packed {
            logic [KEY_BITS-1:0]     key;
            logic [PAYLOAD_BITS-1:0] data;
            logic [1:0]              status;
            logic [CNT_BITS-1:0]     fill;
        } heap_result_t;

        entry_t       slots[CAPACITY];
        int unsigned  held;
        logic         min_order;
        heap_result_t awaited[$];
        int unsigned  mismatches;

        // true when key a sits strictly lower than key b in the current order
        function bit worse(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b);
            return min_order ? (a > b) : (a < b);
        endfunction

        function void note_command(logic [1:0] cmd, logic [KEY_BITS-1:0] key,
                                   logic [PAYLOAD_BITS-1:0] data);
            heap_result_t r;
            int unsigned  hole;
            int unsigned  up;
            int unsigned  c;
            entry_t       moved;
            r = '0;
            case (cmd)
                CMD_INSERT:
                begin
                    if (held >= CAPACITY)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        hole = held;
                        held++;
                        while (hole > 0)
                        begin
                            up = (hole - 1) / 2;
                            if (!worse(slots[up].key, key))
                                break;
                            slots[hole] = slots[up];
                            hole = up;
                        end
                        slots[hole] = {key, data};
                    end
                end
                CMD_REMOVE:
                begin
                    if (held == 0)
                    begin
                        r.status = ST_EMPTY;
                    end
                    else
                    begin
                        r.key  = slots[0].key;
                        r.data = slots[0].data;
                        held--;
                        moved = slots[held];
                        hole = 0;
                        while (2 * hole + 1 < held)
                        begin
                            c = 2 * hole + 1;
                            if (c + 1 < held && worse(slots[c].key, slots[c + 1].key))
                                c++;
                            if (!worse(moved.key, slots[c].key))
                                break;
                            slots[hole] = slots[c];
                            hole = c;
                        end
                        slots[hole] = moved;
                    end
                end
                CMD_CLEAR:
                begin
                    held = 0;
                end
                default:
                begin
                end
            endcase
            r.fill = held[CNT_BITS-1:0];
            awaited.push_back(r);
        endfunction

        function void check_result(logic [KEY_BITS-1:0] key, logic [PAYLOAD_BITS-1:0] data,
                                   logic [1:0] status, logic [CNT_BITS-1:0] fill);
            heap_result_t exp;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result key %h data %h status %0d fill %0d",
                             $realtime, key, data, status, fill);
                return;
            end
            exp = awaited.pop_front();
            if (key !== exp.key || data !== exp.data || status !== exp.status
                || fill !== exp.fill)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: exp key %h data %h st %0d fill %0d, got %h %h %0d %0d",
                             $realtime, exp.key, exp.data, exp.status, exp.fill,
                             key, data, status, fill);
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [1:0]              command;
    logic [KEY_BITS-1:0]     priority_key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    out_valid;
    logic                    out_ready;
    logic [KEY_BITS-1:0]     top_key;
    logic [PAYLOAD_BITS-1:0] top_payload;
    logic [1:0]              status;
    logic [CNT_BITS-1:0]     fill_count;
    logic                    cfg_write_en;
    logic                    cfg_write_data;

    heap_scoreboard board = new;

    int unsigned items_sent = 0;
    int unsigned cycles = 0;
    // set by the stimulus to ask the result side for one long hold-off
    int unsigned hold_req = 0;
    // random idling on both sides while set
    bit          idling_on = 1'b0;

    always #6 clk = ~clk;

    binary_heap_priority_queue dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .priority_key   (priority_key),
        .payload        (payload),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .top_key        (top_key),
        .top_payload    (top_payload),
        .status         (status),
        .fill_count     (fill_count),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // runaway guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // keys lean toward ties and the two extremes now and then
    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(0, 4))
            0:       return KEY_BITS'($urandom_range(0, 7));
            1:       return $urandom_range(0, 1) ? '1 : '0;
            default: return KEY_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // one command transaction; valid stays up afterwards unless a gap is taken
    task automatic send_cmd(input logic [1:0] cmd, input logic [KEY_BITS-1:0] key,
                            input logic [PAYLOAD_BITS-1:0] data);
        in_valid     <= 1'b1;
        command      <= cmd;
        priority_key <= key;
        payload      <= data;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_command(cmd, key, data);
        items_sent++;
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic send_random(input logic [1:0] cmd);
        send_cmd(cmd, pick_key(), PAYLOAD_BITS'($urandom_range(0, 65535)));
    endtask

    // drop valid and wait for every awaited result; the block is idle after this
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() != 0)
            @(posedge clk);
    endtask

    // only called with the block idle
    task automatic set_order(input logic min_heap);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= min_heap;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        board.min_order = min_heap;
    endtask

    // result side: checks every transaction and stalls at random or on request
    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_result(top_key, top_payload, status, fill_count);
            if (hold_req != 0)
            begin
                stall_left = hold_req;
                hold_req = 0;
            end
            else if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10);
            end
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned kind;
        int unsigned n;
        int unsigned roll;
        int unsigned bias;
        in_valid       <= 1'b0;
        command        <= CMD_INSERT;
        priority_key   <= '0;
        payload        <= '0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= 1'b0;
        rst_n          <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_order(1'b0);

        // directed: empty remove, unused code, extremes, ties, clear
        send_cmd(CMD_REMOVE, '0, '0);
        send_cmd(CMD_UNUSED, '1, '1);
        send_cmd(CMD_INSERT, 16'hFFFF, 16'h0000);
        send_cmd(CMD_INSERT, 16'h0000, 16'hFFFF);
        send_cmd(CMD_INSERT, 16'h8000, 16'h1234);
        send_cmd(CMD_INSERT, 16'h8000, 16'h5678);
        send_cmd(CMD_INSERT, 16'h8000, 16'h9ABC);
        send_cmd(CMD_UNUSED, 16'h5555, 16'hAAAA);
        repeat (5) send_cmd(CMD_REMOVE, '0, '0);
        send_cmd(CMD_REMOVE, '1, '1);
        send_cmd(CMD_INSERT, 16'h0001, 16'h0001);
        send_cmd(CMD_INSERT, 16'h0002, 16'h0002);
        send_cmd(CMD_CLEAR, '0, '0);
        send_cmd(CMD_REMOVE, '0, '0);
        send_cmd(CMD_CLEAR, '0, '0);
        send_cmd(CMD_INSERT, 16'd10, 16'h00A0);
        send_cmd(CMD_INSERT, 16'd30, 16'h00A1);
        send_cmd(CMD_INSERT, 16'd20, 16'h00A2);
        settle();
        // order flipped with entries held: no reordering, later removes use the new order
        set_order(1'b1);
        repeat (4) send_cmd(CMD_REMOVE, '0, '0);
        settle();

        // long hold-off on the result side while commands keep coming in
        hold_req = LONG_HOLD;
        repeat (40) send_random($urandom_range(0, 3) == 0 ? CMD_REMOVE : CMD_INSERT);
        settle();

        // random phases, each ending with the block drained
        while (items_sent < ITEM_TARGET)
        begin
            idling_on = (items_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
                set_order(1'($urandom_range(0, 1)));
            kind = $urandom_range(0, 9);
            if (kind <= 2)
            begin
                // fill to the top, then a few refused inserts
                while (board.held < CAPACITY)
                    send_random(CMD_INSERT);
                repeat ($urandom_range(1, 3)) send_random(CMD_INSERT);
            end
            else if (kind <= 4)
            begin
                // drain to empty, then a few refused removes
                while (board.held != 0)
                    send_random(CMD_REMOVE);
                repeat ($urandom_range(1, 3)) send_random(CMD_REMOVE);
            end
            else
            begin
                // mixed traffic steered away from the ends of the range
                n = $urandom_range(20, 60);
                repeat (n)
                begin
                    roll = $urandom_range(0, 99);
                    bias = 50;
                    if (board.held < 8)
                        bias = 70;
                    else if (board.held > 56)
                        bias = 30;
                    if (roll < 2)
                        send_random(CMD_CLEAR);
                    else if (roll < 5)
                        send_random(CMD_UNUSED);
                    else if (roll < bias)
                        send_random(CMD_INSERT);
                    else
                        send_random(CMD_REMOVE);
                end
            end
            settle();
        end

        idling_on = 1'b0;
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.awaited.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
